// ===== hdl/frot_pkg.sv =====
// Shared types, constants and register codes for the frame rotation core.
package frot_pkg;

	localparam int COORD_WIDTH    = 40;
	localparam int TRIG_WIDTH     = 32;
	localparam int TRIG_FRAC_BITS = 30;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 32;

	localparam logic signed [TRIG_WIDTH-1:0] COS_ONE = 32'sh4000_0000;

	typedef enum logic [1:0] {
		MODE_XYZ_ENU = 2'd0,
		MODE_ENU_XYZ = 2'd1,
		MODE_ENU_UVW = 2'd2,
		MODE_XYZ_UVW = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_MODE       = 3'd0,
		REG_SIN_FIRST  = 3'd1,
		REG_COS_FIRST  = 3'd2,
		REG_SIN_SECOND = 3'd3,
		REG_COS_SECOND = 3'd4,
		REG_SIN_THIRD  = 3'd5,
		REG_COS_THIRD  = 3'd6
	} cfg_idx_t;

	// which component pair a rotation stage works on
	typedef enum logic [1:0] {
		PAIR_AB,
		PAIR_AC,
		PAIR_BC,
		PAIR_NONE
	} pair_t;

	typedef struct packed {
		pair_t pair;
		logic  neg_sin;
	} rot_ctl_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] comp_a_in;
		logic signed [COORD_WIDTH-1:0] comp_b_in;
		logic signed [COORD_WIDTH-1:0] comp_c_in;
		logic                          last_in;
	} in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] comp_a_out;
		logic signed [COORD_WIDTH-1:0] comp_b_out;
		logic signed [COORD_WIDTH-1:0] comp_c_out;
		logic                          saturated;
		logic                          last_out;
	} out_t;

	// vector in flight through the rotation chain
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] a;
		logic signed [COORD_WIDTH-1:0] b;
		logic signed [COORD_WIDTH-1:0] c;
		logic                          sat;
		logic                          last;
	} tok_t;

endpackage

// ===== hdl/frot_rot.sv =====
// One plane rotation: split multiply, product merge, sum/round/saturate.
module frot_rot #(
	parameter int FRAC_BITS = frot_pkg::TRIG_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  frot_pkg::rot_ctl_t                    ctl,
	input  logic signed [frot_pkg::TRIG_WIDTH-1:0] sin_val,
	input  logic signed [frot_pkg::TRIG_WIDTH-1:0] cos_val,
	input  logic                                  valid_in,
	input  frot_pkg::tok_t                        tok_in,
	output logic                                  valid_out,
	output frot_pkg::tok_t                        tok_out
);

	localparam int CW  = frot_pkg::COORD_WIDTH;
	localparam int TW  = frot_pkg::TRIG_WIDTH + 1;
	localparam int LW  = CW / 2;
	localparam int HW  = CW - LW;
	localparam int LPW = LW + 1 + TW;
	localparam int HPW = HW + TW;
	localparam int PW  = CW + TW;
	localparam int SW  = PW + 1;
	localparam int TOPW = SW - FRAC_BITS - CW + 1;

	localparam logic signed [SW-1:0] HALF    = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

	function automatic logic signed [LPW-1:0] mul_lo(input logic signed [CW-1:0] x,
			input logic signed [TW-1:0] t);
		return $signed({1'b0, x[LW-1:0]}) * t;
	endfunction

	function automatic logic signed [HPW-1:0] mul_hi(input logic signed [CW-1:0] x,
			input logic signed [TW-1:0] t);
		return $signed(x[CW-1:LW]) * t;
	endfunction

	function automatic logic signed [PW-1:0] merge(input logic signed [HPW-1:0] hi,
			input logic signed [LPW-1:0] lo);
		return (PW'(hi) << LW) + PW'(lo);
	endfunction

	// returns {clip, value}
	function automatic logic [CW:0] rnd_sat(input logic signed [SW-1:0] v);
		logic [TOPW-1:0] top;
		top = v[SW-1:FRAC_BITS+CW-1];
		if (top == '0 || top == '1) begin
			return {1'b0, v[FRAC_BITS+CW-1:FRAC_BITS]};
		end else if (v[SW-1]) begin
			return {1'b1, SAT_MIN};
		end else begin
			return {1'b1, SAT_MAX};
		end
	endfunction

	logic signed [CW-1:0] p_sel, q_sel;
	logic signed [TW-1:0] t_raw, t_s, t_ns, t_c;

	always_comb begin
		case (ctl.pair)
			frot_pkg::PAIR_AB: begin
				p_sel = tok_in.a;
				q_sel = tok_in.b;
			end
			frot_pkg::PAIR_AC: begin
				p_sel = tok_in.a;
				q_sel = tok_in.c;
			end
			default: begin
				p_sel = tok_in.b;
				q_sel = tok_in.c;
			end
		endcase
		t_raw = TW'(sin_val);
		t_s   = ctl.neg_sin ? -t_raw : t_raw;
		t_ns  = -t_s;
		t_c   = TW'(cos_val);
	end

	// stage 1: partial products
	logic                    valid_s1;
	frot_pkg::tok_t          tok_s1;
	logic signed [LPW-1:0]   lo_pc_s1, lo_qns_s1, lo_ps_s1, lo_qc_s1;
	logic signed [HPW-1:0]   hi_pc_s1, hi_qns_s1, hi_ps_s1, hi_qc_s1;

	// stage 2: full products
	logic                    valid_s2;
	frot_pkg::tok_t          tok_s2;
	logic signed [PW-1:0]    pc_s2, qns_s2, ps_s2, qc_s2;

	// stage 3: rotated vector
	logic                    valid_s3;
	frot_pkg::tok_t          tok_s3;

	logic signed [SW-1:0]    sum_p, sum_q;
	logic [CW:0]             res_p, res_q;
	frot_pkg::tok_t          tok_rot;

	always_comb begin
		sum_p   = SW'(pc_s2) + SW'(qns_s2) + HALF;
		sum_q   = SW'(ps_s2) + SW'(qc_s2) + HALF;
		res_p   = rnd_sat(sum_p);
		res_q   = rnd_sat(sum_q);
		tok_rot = tok_s2;
		case (ctl.pair)
			frot_pkg::PAIR_AB: begin
				tok_rot.a = res_p[CW-1:0];
				tok_rot.b = res_q[CW-1:0];
			end
			frot_pkg::PAIR_AC: begin
				tok_rot.a = res_p[CW-1:0];
				tok_rot.c = res_q[CW-1:0];
			end
			frot_pkg::PAIR_BC: begin
				tok_rot.b = res_p[CW-1:0];
				tok_rot.c = res_q[CW-1:0];
			end
			default: begin
				tok_rot = tok_s2;
			end
		endcase
		if (ctl.pair != frot_pkg::PAIR_NONE) begin
			tok_rot.sat = tok_s2.sat | res_p[CW] | res_q[CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s1    <= tok_in;
			lo_pc_s1  <= mul_lo(p_sel, t_c);
			hi_pc_s1  <= mul_hi(p_sel, t_c);
			lo_qns_s1 <= mul_lo(q_sel, t_ns);
			hi_qns_s1 <= mul_hi(q_sel, t_ns);
			lo_ps_s1  <= mul_lo(p_sel, t_s);
			hi_ps_s1  <= mul_hi(p_sel, t_s);
			lo_qc_s1  <= mul_lo(q_sel, t_c);
			hi_qc_s1  <= mul_hi(q_sel, t_c);

			tok_s2    <= tok_s1;
			pc_s2     <= merge(hi_pc_s1, lo_pc_s1);
			qns_s2    <= merge(hi_qns_s1, lo_qns_s1);
			ps_s2     <= merge(hi_ps_s1, lo_ps_s1);
			qc_s2     <= merge(hi_qc_s1, lo_qc_s1);

			tok_s3    <= tok_rot;
		end
	end

	assign valid_out = valid_s3;
	assign tok_out   = tok_s3;

endmodule

// ===== hdl/frot_obuf.sv =====
// Output register with one skid entry; freezes the pipeline when the skid is full.
module frot_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  frot_pkg::out_t push_data,
	output logic           en,
	output logic           out_valid,
	input  logic           out_stall,
	output frot_pkg::out_t out_data
);

	logic           out_valid_q, skid_valid_q;
	frot_pkg::out_t out_q, skid_q;
	logic           pop, push;

	assign en   = !skid_valid_q;
	assign pop  = out_valid_q && !out_stall;
	assign push = push_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/frame_rotation_enu_xyz_uvw_core.sv =====
// Top level: config registers, three-rotation chain and output buffering.
//
//  port group   dir  handshake           payload
//  in_*         in   in_valid/in_stall   frot_pkg::in_t
//  out_*        out  out_valid/out_stall frot_pkg::out_t
//  cfg_*        in   cfg_we              cfg_index, cfg_data
//
// One vector per cycle while in_stall is low: three rotation units of three
// stages each (split multiply, product merge, round/saturate) plus the
// output register. Mode 0/1/3 pass through the third unit's stages unrotated.
// Reset clears config to identity rotations and empties the pipeline.
// A stalled output parks one result in the skid entry; in_stall is that
// entry's full flag and freezes the whole chain while it is set.
module frame_rotation_enu_xyz_uvw_core #(
	parameter int TRIG_FRAC_BITS = frot_pkg::TRIG_FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  frot_pkg::in_t                         in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output frot_pkg::out_t                        out_data,
	input  logic                                  cfg_we,
	input  logic [frot_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [frot_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	frot_pkg::mode_t                        mode_q;
	logic signed [frot_pkg::TRIG_WIDTH-1:0] sin1_q, cos1_q, sin2_q, cos2_q, sin3_q, cos3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= frot_pkg::MODE_XYZ_ENU;
			sin1_q <= '0;
			cos1_q <= frot_pkg::COS_ONE;
			sin2_q <= '0;
			cos2_q <= frot_pkg::COS_ONE;
			sin3_q <= '0;
			cos3_q <= frot_pkg::COS_ONE;
		end else if (cfg_we) begin
			unique case (frot_pkg::cfg_idx_t'(cfg_index))
				frot_pkg::REG_MODE:       mode_q <= frot_pkg::mode_t'(cfg_data[1:0]);
				frot_pkg::REG_SIN_FIRST:  sin1_q <= cfg_data[frot_pkg::TRIG_WIDTH-1:0];
				frot_pkg::REG_COS_FIRST:  cos1_q <= cfg_data[frot_pkg::TRIG_WIDTH-1:0];
				frot_pkg::REG_SIN_SECOND: sin2_q <= cfg_data[frot_pkg::TRIG_WIDTH-1:0];
				frot_pkg::REG_COS_SECOND: cos2_q <= cfg_data[frot_pkg::TRIG_WIDTH-1:0];
				frot_pkg::REG_SIN_THIRD:  sin3_q <= cfg_data[frot_pkg::TRIG_WIDTH-1:0];
				frot_pkg::REG_COS_THIRD:  cos3_q <= cfg_data[frot_pkg::TRIG_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	frot_pkg::rot_ctl_t ctl1, ctl2, ctl3;

	always_comb begin
		ctl2 = '{pair: frot_pkg::PAIR_AC, neg_sin: 1'b1};
		unique case (mode_q) inside
			frot_pkg::MODE_XYZ_ENU, frot_pkg::MODE_XYZ_UVW: begin
				ctl1 = '{pair: frot_pkg::PAIR_AB, neg_sin: 1'b1};
				ctl3 = '{pair: frot_pkg::PAIR_NONE, neg_sin: 1'b0};
			end
			frot_pkg::MODE_ENU_XYZ: begin
				ctl1 = '{pair: frot_pkg::PAIR_BC, neg_sin: 1'b1};
				ctl3 = '{pair: frot_pkg::PAIR_NONE, neg_sin: 1'b0};
			end
			default: begin
				ctl1 = '{pair: frot_pkg::PAIR_BC, neg_sin: 1'b1};
				ctl3 = '{pair: frot_pkg::PAIR_BC, neg_sin: 1'b0};
			end
		endcase
	end

	logic           en;
	logic           v1, v2, v3;
	frot_pkg::tok_t tok0, tok1, tok2, tok3;
	frot_pkg::out_t res;

	assign tok0 = '{a: in_data.comp_a_in, b: in_data.comp_b_in, c: in_data.comp_c_in,
			sat: 1'b0, last: in_data.last_in};

	frot_rot #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot1 (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl(ctl1),
		.sin_val(sin1_q), .cos_val(cos1_q),
		.valid_in(in_valid), .tok_in(tok0), .valid_out(v1), .tok_out(tok1)
	);

	frot_rot #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot2 (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl(ctl2),
		.sin_val(sin2_q), .cos_val(cos2_q),
		.valid_in(v1), .tok_in(tok1), .valid_out(v2), .tok_out(tok2)
	);

	frot_rot #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rot3 (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl(ctl3),
		.sin_val(sin3_q), .cos_val(cos3_q),
		.valid_in(v2), .tok_in(tok2), .valid_out(v3), .tok_out(tok3)
	);

	always_comb begin
		res.saturated = tok3.sat;
		res.last_out  = tok3.last;
		unique case (mode_q) inside
			frot_pkg::MODE_XYZ_ENU, frot_pkg::MODE_XYZ_UVW: begin
				res.comp_a_out = tok3.b;
				res.comp_b_out = tok3.c;
				res.comp_c_out = tok3.a;
			end
			frot_pkg::MODE_ENU_XYZ: begin
				res.comp_a_out = tok3.c;
				res.comp_b_out = tok3.a;
				res.comp_c_out = tok3.b;
			end
			default: begin
				res.comp_a_out = tok3.a;
				res.comp_b_out = tok3.b;
				res.comp_c_out = tok3.c;
			end
		endcase
	end

	frot_obuf u_obuf (
		.clk(clk), .arst_n(arst_n), .push_valid(v3), .push_data(res), .en(en),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	assign in_stall = !en;

endmodule

// ===== hdl/frot_chk.sv =====
// Port-level checker for the frame rotation core, bound to the top level.
module frot_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input frot_pkg::out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output transfer changed while stalled");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall rose without an output stall");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_valid && !out_stall |=> !in_stall)
		else $error("input stall held after output transfer");

endmodule

bind frame_rotation_enu_xyz_uvw_core frot_chk u_frot_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the frame rotation core: directed script, random phases, scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import frot_pkg::*;

	localparam int PHASES         = 9;
	localparam int PHASE_VECTORS  = 50;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
	localparam logic [31:0] SIN_45     = 32'h2D41_3CCD;
	localparam logic [31:0] NEG_SIN_45 = 32'hD2BE_C333;

	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [95:0] COORD_MAX  = (96'sd1 <<< (COORD_WIDTH-1)) - 96'sd1;
	localparam logic signed [95:0] COORD_MIN  = -(96'sd1 <<< (COORD_WIDTH-1));
	localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< (TRIG_FRAC_BITS-1);

	typedef struct {
		logic                     is_write;
		logic [CFG_IDX_WIDTH-1:0] idx;
		logic [31:0]              val;
		in_t                      vec;
		logic                     typed;
		out_t                     want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	mode_t cfg_mode;
	logic signed [TRIG_WIDTH+1:0] sin_val [0:2];
	logic signed [TRIG_WIDTH+1:0] cos_val [0:2];

	out_t pending_vectors [$];
	script_row_t script [$];
	out_t oldest;
	int send_idle_pct;
	int recv_idle_pct;
	logic long_hold_req = 1'b0;
	int mismatch_cnt = 0;
	int sent_cnt = 0;
	int checked_cnt = 0;
	int sat_cnt = 0;
	int write_cnt = 0;
	int idle_cycles;

	frame_rotation_enu_xyz_uvw_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [COORD_WIDTH-1:0] round_clip(input logic signed [95:0] v,
			inout logic clip);
		logic signed [95:0] r;
		r = (v + ROUND_HALF) >>> TRIG_FRAC_BITS;
		if (r > COORD_MAX) begin
			clip = 1'b1;
			r = COORD_MAX;
		end else if (r < COORD_MIN) begin
			clip = 1'b1;
			r = COORD_MIN;
		end
		return r[COORD_WIDTH-1:0];
	endfunction

	// p' = k*p - s*q, q' = s*p + k*q
	function automatic void rotate_pair(inout logic signed [COORD_WIDTH-1:0] p,
			inout logic signed [COORD_WIDTH-1:0] q, input logic signed [TRIG_WIDTH+1:0] s,
			input logic signed [TRIG_WIDTH+1:0] k, inout logic clip);
		logic signed [95:0] pw, qw, sw, kw;
		pw = 96'(p);
		qw = 96'(q);
		sw = 96'(s);
		kw = 96'(k);
		p = round_clip(kw * pw - sw * qw, clip);
		q = round_clip(sw * pw + kw * qw, clip);
	endfunction

	function automatic out_t rotate_vector(in_t v);
		logic signed [COORD_WIDTH-1:0] a, b, c;
		logic clip;
		out_t r;
		a = v.comp_a_in;
		b = v.comp_b_in;
		c = v.comp_c_in;
		clip = 1'b0;
		case (cfg_mode)
			MODE_ENU_XYZ: begin
				rotate_pair(b, c, -sin_val[0], cos_val[0], clip);
				rotate_pair(a, c, -sin_val[1], cos_val[1], clip);
				r.comp_a_out = c;
				r.comp_b_out = a;
				r.comp_c_out = b;
			end
			MODE_ENU_UVW: begin
				rotate_pair(b, c, -sin_val[0], cos_val[0], clip);
				rotate_pair(a, c, -sin_val[1], cos_val[1], clip);
				rotate_pair(b, c, sin_val[2], cos_val[2], clip);
				r.comp_a_out = a;
				r.comp_b_out = b;
				r.comp_c_out = c;
			end
			default: begin
				rotate_pair(a, b, -sin_val[0], cos_val[0], clip);
				rotate_pair(a, c, -sin_val[1], cos_val[1], clip);
				r.comp_a_out = b;
				r.comp_b_out = c;
				r.comp_c_out = a;
			end
		endcase
		r.saturated = clip;
		r.last_out = v.last_in;
		return r;
	endfunction

	function automatic void add_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] val);
		script_row_t r;
		r.is_write = 1'b1;
		r.idx = idx;
		r.val = val;
		r.vec = '0;
		r.typed = 1'b0;
		r.want = '0;
		script.push_back(r);
	endfunction

	function automatic void add_vec(logic signed [COORD_WIDTH-1:0] a,
			logic signed [COORD_WIDTH-1:0] b, logic signed [COORD_WIDTH-1:0] c, logic last);
		script_row_t r;
		r.is_write = 1'b0;
		r.idx = '0;
		r.val = '0;
		r.vec = '{a, b, c, last};
		r.typed = 1'b0;
		r.want = '0;
		script.push_back(r);
	endfunction

	function automatic void add_check(logic signed [COORD_WIDTH-1:0] a,
			logic signed [COORD_WIDTH-1:0] b, logic signed [COORD_WIDTH-1:0] c, logic last,
			logic signed [COORD_WIDTH-1:0] oa, logic signed [COORD_WIDTH-1:0] ob,
			logic signed [COORD_WIDTH-1:0] oc, logic sat);
		script_row_t r;
		r.is_write = 1'b0;
		r.idx = '0;
		r.val = '0;
		r.vec = '{a, b, c, last};
		r.typed = 1'b1;
		r.want = '{oa, ob, oc, sat, last};
		script.push_back(r);
	endfunction

	function automatic logic [31:0] pick_trig(int ph);
		case (ph)
			0: return COS_ONE;
			1: return -COS_ONE;
			2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: begin
				case ($urandom_range(5))
					0: return $urandom();
					1: return 32'd0;
					default: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
				endcase
			end
		endcase
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
		logic [31:0] upper;
		upper = $urandom();
		case ($urandom_range(9))
			0: return C_MAX;
			1: return C_MIN;
			2: return COORD_WIDTH'($urandom_range(2000)) - COORD_WIDTH'(1000);
			3: return COORD_WIDTH'(signed'(upper));
			default: return {upper[COORD_WIDTH-33:0], 32'($urandom())};
		endcase
	endfunction

	task automatic wait_for_results();
		in_valid <= 1'b0;
		wait (pending_vectors.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] val);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:       cfg_mode = mode_t'(val[1:0]);
			REG_SIN_FIRST:  sin_val[0] = (TRIG_WIDTH+2)'(signed'(val));
			REG_COS_FIRST:  cos_val[0] = (TRIG_WIDTH+2)'(signed'(val));
			REG_SIN_SECOND: sin_val[1] = (TRIG_WIDTH+2)'(signed'(val));
			REG_COS_SECOND: cos_val[1] = (TRIG_WIDTH+2)'(signed'(val));
			REG_SIN_THIRD:  sin_val[2] = (TRIG_WIDTH+2)'(signed'(val));
			REG_COS_THIRD:  cos_val[2] = (TRIG_WIDTH+2)'(signed'(val));
			default: ;
		endcase
		write_cnt++;
	endtask

	task automatic push_vector(in_t v, logic typed, out_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_vectors.push_back(typed ? want : rotate_vector(v));
		sent_cnt++;
	endtask

	// receiver: random stall, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_vectors.size() == 0) begin
				if (mismatch_cnt < REPORT_LIMIT)
					$display("ERROR %0t: result with nothing pending: a=%0d b=%0d c=%0d",
						$realtime, out_data.comp_a_out, out_data.comp_b_out,
						out_data.comp_c_out);
				mismatch_cnt++;
			end else begin
				oldest = pending_vectors.pop_front();
				checked_cnt++;
				if (out_data.saturated)
					sat_cnt++;
				if (out_data.comp_a_out !== oldest.comp_a_out ||
						out_data.comp_b_out !== oldest.comp_b_out ||
						out_data.comp_c_out !== oldest.comp_c_out ||
						out_data.saturated !== oldest.saturated ||
						out_data.last_out !== oldest.last_out) begin
					if (mismatch_cnt < REPORT_LIMIT) begin
						$display("ERROR %0t: exp a=%0d b=%0d c=%0d sat=%b last=%b",
							$realtime, oldest.comp_a_out, oldest.comp_b_out,
							oldest.comp_c_out, oldest.saturated, oldest.last_out);
						$display("      got a=%0d b=%0d c=%0d sat=%b last=%b",
							out_data.comp_a_out, out_data.comp_b_out, out_data.comp_c_out,
							out_data.saturated, out_data.last_out);
					end
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Watchdog: no transfer for %0d cycles, %0d results pending",
			WATCHDOG_LIMIT, pending_vectors.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int ph, n, r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cfg_mode = MODE_XYZ_ENU;
		for (r = 0; r < 3; r++) begin
			sin_val[r] = '0;
			cos_val[r] = (TRIG_WIDTH+2)'(COS_ONE);
		end
		send_idle_pct = 18;
		recv_idle_pct = 79;

		// identity rotations after reset: only the output permutation shows
		add_check(1, 2, 3, 0, 2, 3, 1, 0);
		add_check(C_MAX, C_MIN, -1, 1, C_MIN, -1, C_MAX, 0);
		add_check(0, 0, 0, 0, 0, 0, 0, 0);
		add_check(C_MIN, C_MIN, C_MIN, 1, C_MIN, C_MIN, C_MIN, 0);
		add_write(REG_UNUSED, 32'hDEAD_BEEF);
		add_check(5, 6, 7, 0, 6, 7, 5, 0);
		add_write(REG_MODE, 32'hABCD_0000 | 32'(MODE_ENU_XYZ));
		add_check(1, 2, 3, 1, 3, 1, 2, 0);
		add_write(REG_MODE, 32'(MODE_ENU_UVW));
		add_check(1, 2, 3, 0, 1, 2, 3, 0);
		add_write(REG_MODE, 32'(MODE_XYZ_UVW));
		add_check(1, 2, 3, 0, 2, 3, 1, 0);
		// cosine near +2 and at -2 drives the first step out of range
		add_write(REG_MODE, 32'(MODE_XYZ_ENU));
		add_write(REG_COS_FIRST, 32'h7FFF_FFFF);
		add_check(C_MAX, 0, 0, 0, 0, 0, C_MAX, 1);
		add_write(REG_COS_FIRST, 32'h8000_0000);
		add_check(C_MAX, 0, 0, 0, 0, 0, C_MIN, 1);
		add_check(C_MIN, 0, 0, 0, 0, 0, C_MAX, 1);
		add_check(1, 2, 3, 0, -4, 3, -2, 0);
		// third pair must not matter outside enu to uvw
		add_write(REG_COS_FIRST, COS_ONE);
		add_write(REG_SIN_THIRD, SIN_45);
		add_write(REG_COS_THIRD, 32'h8000_0000);
		add_check(1, 2, 3, 0, 2, 3, 1, 0);
		add_write(REG_MODE, 32'(MODE_ENU_UVW));
		add_vec(C_MAX, C_MIN, C_MAX, 1);
		add_vec(123456789, -987654321, 55555, 0);
		add_write(REG_SIN_FIRST, COS_ONE);
		add_write(REG_COS_FIRST, 32'd0);
		add_write(REG_SIN_SECOND, NEG_SIN_45);
		add_write(REG_COS_SECOND, SIN_45);
		add_vec(C_MIN, C_MAX, -1, 0);
		add_vec(1000000, 2000000, -3000000, 1);
		add_write(REG_MODE, 32'(MODE_ENU_XYZ));
		add_vec(C_MIN, C_MIN, C_MIN, 0);
		add_vec(7, -7, 1, 0);
		add_write(REG_MODE, 32'(MODE_XYZ_UVW));
		add_write(REG_SIN_FIRST, 32'h8000_0000);
		add_write(REG_SIN_SECOND, 32'h7FFF_FFFF);
		add_vec(C_MAX, C_MAX, C_MAX, 1);
		add_vec(-5, 3, 1, 0);
		add_write(REG_MODE, 32'(MODE_XYZ_ENU));
		add_vec(C_MIN, C_MAX, 0, 0);
		add_vec(12345, -1, 99999, 1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_write)
				write_reg(script[i].idx, script[i].val);
			else
				push_vector(script[i].vec, script[i].typed, script[i].want);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph / 3)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(REG_MODE, (32'($urandom()) & ~32'd3) | 32'(ph % 4));
			for (r = 1; r < 7; r++)
				write_reg(CFG_IDX_WIDTH'(r), pick_trig(ph));
			for (n = 0; n < PHASE_VECTORS; n++) begin
				if (ph == 6 && n == 10)
					long_hold_req = 1'b1;
				if (ph == 7 && n == 25)
					wait_for_results();
				push_vector('{pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(7) == 0}, 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d vectors over all four modes, %0d register writes incl. extremes",
			sent_cnt, write_cnt);
		$display("Checked %0d results (%0d saturated), %0d mismatches",
			checked_cnt, sat_cnt, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
